@@ rtl/core/abpw_pkg.sv @@
package abpw_pkg;

  // largest frame side; registers above it clamp to it
  localparam int unsigned MaxSide = 4096;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned SideW   = 13;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned PosW    = 16;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned IndexW  = 24;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'd1;

  localparam logic [CfgW-1:0] ResetWidth  = 13'd320;
  localparam logic [CfgW-1:0] ResetHeight = 13'd240;

  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] AlphaHalf   = 8'h7F;
  localparam logic [7:0] AlphaClear  = 8'h00;

  typedef enum logic [1:0] {
    KIND_COPY,
    KIND_AVG,
    KIND_BLEND
  } blend_kind_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    blend_kind_e       kind;
    logic [ColorW-1:0] src;
    logic [ColorW-1:0] dst;
  } pix_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [SideW-1:0] clamp_side(input logic [CfgW-1:0] v);
    logic [SideW-1:0] lim;
    lim = SideW'(MaxSide);
    return (v > lim) ? lim : v;
  endfunction

endpackage

@@ rtl/core/abpw_front.sv @@
module abpw_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic signed [abpw_pkg::PosW-1:0] pos_x_i,
  input  logic signed [abpw_pkg::PosW-1:0] pos_y_i,
  input  logic [abpw_pkg::ColorW-1:0]     src_color_i,
  input  logic [abpw_pkg::ColorW-1:0]     dest_pixel_i,
  input  logic [abpw_pkg::SideW-1:0]      width_i,
  input  logic [abpw_pkg::SideW-1:0]      height_i,
  input  abpw_pkg::fifo_status_t          fifo_st_i,
  output logic                            fifo_push_o,
  output abpw_pkg::pix_item_t             fifo_item_o
);

  logic                valid_q, valid_d;
  abpw_pkg::pix_item_t item_q, item_d;
  logic                ready;
  logic                accept;
  logic                keep;
  logic                in_x, in_y;
  logic [7:0]          alpha;

  assign alpha = src_color_i[31:24];
  assign in_x  = !pos_x_i[abpw_pkg::PosW-1] &&
                 ({1'b0, pos_x_i[abpw_pkg::PosW-2:0]} <
                  abpw_pkg::PosW'(width_i));
  assign in_y  = !pos_y_i[abpw_pkg::PosW-1] &&
                 ({1'b0, pos_y_i[abpw_pkg::PosW-2:0]} <
                  abpw_pkg::PosW'(height_i));
  assign keep  = in_x && in_y && (alpha != abpw_pkg::AlphaClear);

  assign fifo_push_o = valid_q && !fifo_st_i.full;
  assign ready       = !valid_q || !fifo_st_i.full;
  assign full_o      = !ready;
  assign accept      = push_i && ready;
  assign fifo_item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (fifo_push_o) begin
      valid_d = 1'b0;
    end
    // clipped and transparent pixels are dropped here
    if (accept) begin
      valid_d     = keep;
      item_d.x    = pos_x_i[abpw_pkg::CoordW-1:0];
      item_d.y    = pos_y_i[abpw_pkg::CoordW-1:0];
      item_d.src  = src_color_i;
      item_d.dst  = dest_pixel_i;
      if (alpha == abpw_pkg::AlphaOpaque) begin
        item_d.kind = abpw_pkg::KIND_COPY;
      end else if (alpha == abpw_pkg::AlphaHalf) begin
        item_d.kind = abpw_pkg::KIND_AVG;
      end else begin
        item_d.kind = abpw_pkg::KIND_BLEND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ rtl/core/abpw_fifo.sv @@
module abpw_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  abpw_pkg::pix_item_t    item_i,
  input  logic                   pop_i,
  output abpw_pkg::pix_item_t    item_o,
  output abpw_pkg::fifo_status_t status_o
);

  abpw_pkg::pix_item_t                 mem_q [abpw_pkg::FifoDepth];
  logic [abpw_pkg::FifoPtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [abpw_pkg::FifoCntW-1:0]       cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == abpw_pkg::FifoCntW'(abpw_pkg::FifoDepth));
  assign status_o.empty = (cnt_q == '0);
  assign item_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!status_o.full || pop_i))
    else $error("fifo push while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("fifo pop while empty");

  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("fifo count did not follow push");

endmodule

@@ rtl/core/abpw_back.sv @@
module abpw_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  abpw_pkg::fifo_status_t         fifo_st_i,
  input  abpw_pkg::pix_item_t            fifo_item_i,
  output logic                           fifo_pop_o,
  input  logic [abpw_pkg::SideW-1:0]     width_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [abpw_pkg::IndexW-1:0]    pixel_index_o,
  output logic [abpw_pkg::ColorW-1:0]    pixel_value_o
);

  localparam int unsigned RowW = abpw_pkg::CoordW + abpw_pkg::SideW;

  // stage 1: row offset and channel products
  logic                          s1_valid_q, s1_valid_d;
  logic [RowW-1:0]               s1_row_q;
  logic [abpw_pkg::CoordW-1:0]   s1_x_q;
  abpw_pkg::blend_kind_e         s1_kind_q;
  logic [abpw_pkg::ColorW-1:0]   s1_src_q, s1_dst_q;
  logic [7:0]                    s1_hi_q [3];
  logic [7:0]                    hi_d [3];

  // stage 2: output register
  logic                          out_valid_q, out_valid_d;
  logic [abpw_pkg::IndexW-1:0]   out_idx_q, out_idx_d;
  logic [abpw_pkg::ColorW-1:0]   out_val_q, out_val_d;

  logic                          s2_ready, s1_ready;
  logic [8:0]                    alpha_p1;
  logic [RowW-1:0]               row_d;
  logic [RowW-1:0]               idx_sum;
  logic [8:0]                    sum_r, sum_g, sum_b;
  logic [7:0]                    old_c [3];

  assign s2_ready   = !out_valid_q || pop_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign fifo_pop_o = !fifo_st_i.empty && s1_ready;

  assign alpha_p1 = {1'b0, fifo_item_i.src[31:24]} + 9'd1;
  assign row_d    = RowW'(fifo_item_i.y) * RowW'(width_i);

  always_comb begin
    logic signed [8:0]  diff;
    logic signed [18:0] prod;
    for (int c = 0; c < 3; c++) begin
      diff    = $signed({1'b0, fifo_item_i.src[8*c +: 8]}) -
                $signed({1'b0, fifo_item_i.dst[8*c +: 8]});
      prod    = 19'(diff) * 19'($signed({1'b0, alpha_p1}));
      // floor shift by 8, low byte only
      hi_d[c] = prod[15:8];
    end
  end

  assign s1_valid_d = fifo_pop_o ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) begin
      s1_row_q  <= row_d;
      s1_x_q    <= fifo_item_i.x;
      s1_kind_q <= fifo_item_i.kind;
      s1_src_q  <= fifo_item_i.src;
      s1_dst_q  <= fifo_item_i.dst;
      s1_hi_q   <= hi_d;
    end
  end

  assign idx_sum = s1_row_q + RowW'(s1_x_q);
  assign sum_r   = {1'b0, s1_src_q[23:16]} + {1'b0, s1_dst_q[23:16]};
  assign sum_g   = {1'b0, s1_src_q[15:8]}  + {1'b0, s1_dst_q[15:8]};
  assign sum_b   = {1'b0, s1_src_q[7:0]}   + {1'b0, s1_dst_q[7:0]};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      old_c[c] = s1_dst_q[8*c +: 8];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_valid_q && s2_ready) begin
      out_valid_d = 1'b1;
      out_idx_d   = idx_sum[abpw_pkg::IndexW-1:0];
      case (s1_kind_q)
        abpw_pkg::KIND_COPY: out_val_d = s1_src_q;
        abpw_pkg::KIND_AVG:  out_val_d = {abpw_pkg::AlphaClear, sum_r[8:1],
                                          sum_g[8:1], sum_b[8:1]};
        default:             out_val_d = {s1_dst_q[31:24],
                                          old_c[2] + s1_hi_q[2],
                                          old_c[1] + s1_hi_q[1],
                                          old_c[0] + s1_hi_q[0]};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q <= out_idx_d;
    out_val_q <= out_val_d;
  end

  assign empty_o       = !out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign pixel_value_o = out_val_q;

  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_row_q)))
    else $error("stage 1 item lost while output stalled");

  a_out_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_val_q)))
    else $error("output result changed while waiting");

  a_pop_gated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |-> !fifo_pop_o)
    else $error("fifo popped into a stalled stage");

endmodule

@@ rtl/core/alpha_blend_pixel_writer_unit.sv @@
// alpha blending pixel writer, one ARGB8888 pixel per request
//
// input queue: push_i with pos_x_i, pos_y_i, src_color_i and dest_pixel_i is
// taken at a clock edge where push_i is high and full_o is low. pixels
// outside the frame, or with a zero source alpha, are dropped in the front
// stage and give no result. result queue: while empty_o is low the oldest
// result (pixel_index_o, pixel_value_o) is shown; pop_i takes it.
// config: cfg_valid_i with cfg_index_i (0 frame width, 1 frame height) and
// cfg_data_i; cfg_ready_o is always high. sides above 4096 clamp to 4096.
// path: front register, then the queue, stage 1 and the output register.
// one request per cycle is sustained while pop_i keeps up; the front
// register (one item), a four-entry queue and a two-stage back end (row
// multiply and channel products, then adds; one item per stage) hold seven
// items in all, so a stalled receiver fills them before full_o rises.
// reset: all queues empty, frame width 320 and height 240.
module alpha_blend_pixel_writer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic signed [abpw_pkg::PosW-1:0]   pos_x_i,
  input  logic signed [abpw_pkg::PosW-1:0]   pos_y_i,
  input  logic [abpw_pkg::ColorW-1:0]        src_color_i,
  input  logic [abpw_pkg::ColorW-1:0]        dest_pixel_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic [abpw_pkg::IndexW-1:0]        pixel_index_o,
  output logic [abpw_pkg::ColorW-1:0]        pixel_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [abpw_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [abpw_pkg::CfgW-1:0]          cfg_data_i
);

  logic [abpw_pkg::CfgW-1:0]  width_q, width_d, height_q, height_d;
  logic [abpw_pkg::SideW-1:0] width_eff, height_eff;

  abpw_pkg::fifo_status_t fifo_st;
  abpw_pkg::pix_item_t    push_item, pop_item;
  logic                   fifo_push, fifo_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        abpw_pkg::RegFrameWidth:  width_d  = cfg_data_i;
        abpw_pkg::RegFrameHeight: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= abpw_pkg::ResetWidth;
      height_q <= abpw_pkg::ResetHeight;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign width_eff  = abpw_pkg::clamp_side(width_q);
  assign height_eff = abpw_pkg::clamp_side(height_q);

  abpw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .src_color_i  (src_color_i),
    .dest_pixel_i (dest_pixel_i),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .fifo_st_i    (fifo_st),
    .fifo_push_o  (fifo_push),
    .fifo_item_o  (push_item)
  );

  abpw_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fifo_push),
    .item_i   (push_item),
    .pop_i    (fifo_pop),
    .item_o   (pop_item),
    .status_o (fifo_st)
  );

  abpw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_st_i     (fifo_st),
    .fifo_item_i   (pop_item),
    .fifo_pop_o    (fifo_pop),
    .width_i       (width_eff),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .pixel_index_o (pixel_index_o),
    .pixel_value_o (pixel_value_o)
  );

endmodule
